[sv/aesp_pkg.sv]
// Shared types and constants for the SGR escape parser.
`timescale 1ns / 1ps
package aesp_pkg;
	localparam int ParamDepth = 64;
	localparam int PtrW = $clog2(ParamDepth);
	localparam int CntW = $clog2(ParamDepth + 1);
	localparam logic [15:0] NumMax = 16'hFFFF;

	localparam logic [2:0] EV_CHAR = 3'd0;
	localparam logic [2:0] EV_LF = 3'd1;
	localparam logic [2:0] EV_CR = 3'd2;
	localparam logic [2:0] EV_BS = 3'd3;
	localparam logic [2:0] EV_TAB = 3'd4;
	localparam logic [2:0] EV_EL = 3'd5;
	localparam logic [2:0] EV_ED = 3'd6;

	localparam logic [1:0] SRC_DEFAULT = 2'd0;
	localparam logic [1:0] SRC_INDEX = 2'd1;
	localparam logic [1:0] SRC_RGB = 2'd2;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [15:0] char_code;
		logic [15:0] erase_mode;
		logic [5:0] attributes;
		logic [1:0] fg_source;
		logic [7:0] fg_index;
		logic [23:0] fg_rgb;
		logic [1:0] bg_source;
		logic [7:0] bg_index;
		logic [23:0] bg_rgb;
	} event_t;

	typedef struct packed {
		logic [5:0] flags;
		logic [1:0] fsrc;
		logic [7:0] fidx;
		logic [23:0] frgb;
		logic [1:0] bsrc;
		logic [7:0] bidx;
		logic [23:0] brgb;
	} style_t;

	function automatic logic [7:0] clamp255(input logic [15:0] v);
		return (v > 16'd255) ? 8'hFF : v[7:0];
	endfunction
endpackage

[sv/aesp_if.sv]
// Valid/ready channel interfaces for code units and events.
`timescale 1ns / 1ps
interface aesp_in_if;
	logic valid;
	logic ready;
	logic [15:0] code_unit;
	modport source(output valid, output code_unit, input ready);
	modport sink(input valid, input code_unit, output ready);
endinterface

interface aesp_out_if;
	import aesp_pkg::*;
	logic valid;
	logic ready;
	event_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[sv/aesp_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module aesp_ram #(
	parameter int Width = 8,
	parameter int Depth = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[sv/ansi_escape_sgr_parser_core.sv]
// Top level: escape-sequence parser with SGR styling.
// Channels: in (one 16-bit code unit per beat), out (one event per beat).
// Ground text, controls, escape and OSC units do not start a walk.
// CSI parameter bytes are written into a 64-entry parameter RAM.
// An m, K or J final byte after parameters walks the RAM one character per
// cycle; the next unit is accepted once the walk ends, after the owed empty
// part of a trailing ';' and after any final 38/48 group is drained.
// The walk splits parameters, keeps a window of the last five values and
// applies SGR codes as each parameter closes (delayed while a 38/48
// group may still be pending).
// An event waits in an output register; the next unit is accepted while
// it waits unless a new event must be produced, which stalls on it.
// An erase event at the end of a walk also waits for the output register.
// Reset (arst_n low) returns to ground with the default style; the RAM
// needs no clearing since only written entries are read.
`timescale 1ns / 1ps
module ansi_escape_sgr_parser_core (
	input logic clk,
	input logic arst_n,
	aesp_in_if.sink in,
	aesp_out_if.source out
);
	import aesp_pkg::*;

	typedef enum logic [2:0] {
		S_GROUND, S_ESC, S_CSI, S_OSC, S_OSC_ESC, S_WALK, S_FLUSH
	} state_t;

	state_t st_q;
	logic [CntW-1:0] cnt_q;
	style_t sty_q;
	logic out_v_q;
	event_t out_q;
	logic [2:0] fin_q; // 0 m, 1 K, 2 J
	logic priv_q;
	logic [CntW-1:0] rd_q; // chars issued
	logic rdv_s1;
	logic last_s1;
	// empty part still owed after a trailing ';'
	logic tail_q;
	// per-part accumulator
	logic [15:0] acc_q;
	logic empty_q, bad_q;
	// window of pending parts, oldest at 0
	logic [15:0] wv_q [5];
	logic [4:0] wb_q;
	logic [2:0] wn_q;
	logic [CntW-1:0] pidx_q;

	logic [7:0] rdata;
	logic we;
	logic [7:0] wdat;

	// write stored parameter byte
	assign we = in.valid && in.ready && st_q == S_CSI &&
		!(in.code_unit >= 16'h40 && in.code_unit <= 16'h7E) && cnt_q < CntW'(ParamDepth);
	assign wdat = (in.code_unit > 16'hFF) ? 8'hFF : in.code_unit[7:0];

	aesp_ram #(.Width(8), .Depth(ParamDepth)) u_ram (
		.clk(clk), .we(we), .waddr(cnt_q[PtrW-1:0]), .wdata(wdat),
		.raddr(rd_q[PtrW-1:0]), .rdata(rdata)
	);

	logic ev_need;
	event_t ev_new;
	logic busy;
	logic ld;
	assign busy = st_q == S_WALK || st_q == S_FLUSH;

	// events for the incoming unit or the end of a walk
	always_comb begin
		ev_need = 1'b0;
		ev_new = '0;
		if (st_q == S_GROUND) begin
			ev_need = 1'b1;
			case (in.code_unit)
				16'h0A: ev_new.event_kind = EV_LF;
				16'h0D: ev_new.event_kind = EV_CR;
				16'h08: ev_new.event_kind = EV_BS;
				16'h09: ev_new.event_kind = EV_TAB;
				default: begin
					if (in.code_unit >= 16'h20 || in.code_unit == 16'h0) begin
						ev_new.event_kind = EV_CHAR;
						ev_new.char_code = in.code_unit;
						ev_new.attributes = sty_q.flags;
						ev_new.fg_source = sty_q.fsrc;
						ev_new.fg_index = sty_q.fidx;
						ev_new.fg_rgb = sty_q.frgb;
						ev_new.bg_source = sty_q.bsrc;
						ev_new.bg_index = sty_q.bidx;
						ev_new.bg_rgb = sty_q.brgb;
					end else begin
						ev_need = 1'b0;
					end
				end
			endcase
		end else if (st_q == S_CSI && cnt_q == '0 &&
			(in.code_unit == 16'h4B || in.code_unit == 16'h4A)) begin
			ev_need = 1'b1;
			ev_new.event_kind = (in.code_unit == 16'h4B) ? EV_EL : EV_ED;
		end else if (st_q == S_FLUSH && fin_q != 3'd0) begin
			ev_need = 1'b1;
			ev_new.event_kind = (fin_q == 3'd1) ? EV_EL : EV_ED;
			ev_new.erase_mode = wv_q[0];
		end
	end

	assign in.ready = !busy && !(ev_need && out_v_q && !out.ready);
	assign out.valid = out_v_q;
	assign out.data = out_q;
	assign ld = ev_need && ((st_q == S_FLUSH) ? (!out_v_q || out.ready) :
		(in.valid && in.ready));

	// apply the SGR code at the window head; used gives the parts consumed
	function automatic style_t sgr_apply(input style_t s, input logic [15:0] v [5],
		input logic [4:0] b, input logic [2:0] n, input logic fin, output logic [2:0] used,
		output logic hold);
		style_t r;
		logic [15:0] c;
		r = s;
		c = v[0];
		used = 3'd1;
		hold = 1'b0;
		if (!b[0]) begin
			case (c)
				16'd0: r = '0;
				16'd1: r.flags[0] = 1'b1;
				16'd2: r.flags[1] = 1'b1;
				16'd3: r.flags[2] = 1'b1;
				16'd4: r.flags[3] = 1'b1;
				16'd7: r.flags[4] = 1'b1;
				16'd9: r.flags[5] = 1'b1;
				16'd21, 16'd22: r.flags[1:0] = 2'b00;
				16'd23: r.flags[2] = 1'b0;
				16'd24: r.flags[3] = 1'b0;
				16'd27: r.flags[4] = 1'b0;
				16'd29: r.flags[5] = 1'b0;
				16'd39: r.fsrc = SRC_DEFAULT;
				16'd49: r.bsrc = SRC_DEFAULT;
				16'd38, 16'd48: begin
					if (n < 3'd2) hold = !fin;
					else if (v[1] == 16'd5) begin
						if (n < 3'd3) hold = !fin;
						else begin
							used = 3'd3;
							if (c == 16'd38) begin
								r.fsrc = SRC_INDEX; r.fidx = clamp255(v[2]);
							end else begin
								r.bsrc = SRC_INDEX; r.bidx = clamp255(v[2]);
							end
						end
					end else if (v[1] == 16'd2) begin
						if (n < 3'd5) hold = !fin;
						else begin
							used = 3'd5;
							if (c == 16'd38) begin
								r.fsrc = SRC_RGB;
								r.frgb = {clamp255(v[2]), clamp255(v[3]), clamp255(v[4])};
							end else begin
								r.bsrc = SRC_RGB;
								r.brgb = {clamp255(v[2]), clamp255(v[3]), clamp255(v[4])};
							end
						end
					end
				end
				default: begin
					if (c >= 16'd30 && c <= 16'd37) begin
						r.fsrc = SRC_INDEX; r.fidx = 8'(c - 16'd30);
					end else if (c >= 16'd40 && c <= 16'd47) begin
						r.bsrc = SRC_INDEX; r.bidx = 8'(c - 16'd40);
					end else if (c >= 16'd90 && c <= 16'd97) begin
						r.fsrc = SRC_INDEX; r.fidx = 8'(c - 16'd82);
					end else if (c >= 16'd100 && c <= 16'd107) begin
						r.bsrc = SRC_INDEX; r.bidx = 8'(c - 16'd92);
					end
				end
			endcase
		end
		if (hold) r = s;
		return r;
	endfunction

	// window after appending a closed part and applying head
	logic [15:0] nv [5];
	logic [4:0] nb;
	logic [2:0] nn;
	logic close_part, fin_walk;
	logic [15:0] part_v;
	logic part_b;
	logic [15:0] acc_mul;
	logic [16:0] acc_sum;
	style_t sty_n;
	logic [2:0] used;
	logic hold;
	logic is_digit;

	assign is_digit = rdata >= 8'h30 && rdata <= 8'h39;
	assign acc_mul = (acc_q > 16'd6553) ? NumMax : 16'(acc_q * 16'd10);
	assign acc_sum = {1'b0, acc_mul} + {13'd0, rdata[3:0]};
	// a lone trailing ';' closes a further empty part in the next cycle
	assign close_part = (rdv_s1 && (rdata == 8'h3B || last_s1)) || tail_q;
	assign part_b = (last_s1 && rdata != 8'h3B) ?
		((bad_q || !is_digit)) : bad_q;
	assign part_v = (last_s1 && rdata != 8'h3B) ?
		((bad_q || !is_digit) ? 16'd0 : (acc_sum[16] ? NumMax : acc_sum[15:0])) :
		(bad_q ? 16'd0 : acc_q);
	assign fin_walk = st_q == S_FLUSH;

	// erase keeps only the first part; SGR applies the head
	always_comb begin
		nv = wv_q;
		nb = wb_q;
		nn = wn_q;
		if (close_part && (fin_q == 3'd0 || wn_q == 3'd0)) begin
			nv[wn_q] = part_v;
			nb[wn_q] = part_b && !(last_s1 && rdata != 8'h3B ? 1'b0 : empty_q);
			nn = wn_q + 3'd1;
		end
		sty_n = sty_q;
		used = 3'd0;
		hold = 1'b1;
		if (nn != 3'd0 && fin_q == 3'd0) begin
			sty_n = sgr_apply(sty_q, nv, nb, nn, fin_walk, used, hold);
			if (hold) used = 3'd0;
		end
	end

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_GROUND;
			cnt_q <= '0;
			sty_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			rdv_s1 <= 1'b0;
			last_s1 <= 1'b0;
			tail_q <= 1'b0;
			rd_q <= '0;
			wv_q <= '{default: 16'd0};
			wn_q <= '0;
			wb_q <= '0;
			fin_q <= '0;
			priv_q <= 1'b0;
			empty_q <= 1'b1;
			bad_q <= 1'b0;
			acc_q <= '0;
			pidx_q <= '0;
		end else begin
			// load a new event or drop the one taken
			if (ld) begin
				out_v_q <= 1'b1;
				out_q <= ev_new;
			end else if (out.ready) out_v_q <= 1'b0;
			if (in.valid && in.ready) begin
				case (st_q)
					S_ESC: begin
						if (in.code_unit == 16'h5B) begin
							cnt_q <= '0; st_q <= S_CSI;
						end else if (in.code_unit == 16'h5D) st_q <= S_OSC;
						else st_q <= S_GROUND;
					end
					S_CSI: begin
						if (in.code_unit >= 16'h40 && in.code_unit <= 16'h7E) begin
							fin_q <= (in.code_unit == 16'h6D) ? 3'd0 :
								(in.code_unit == 16'h4B) ? 3'd1 :
								(in.code_unit == 16'h4A) ? 3'd2 : 3'd3;
							if (in.code_unit == 16'h6D && cnt_q == '0) begin
								sty_q <= '0; st_q <= S_GROUND;
							end else if (in.code_unit == 16'h4B || in.code_unit == 16'h4A) begin
								if (cnt_q == '0) st_q <= S_GROUND;
								else st_q <= S_WALK;
							end else if (in.code_unit == 16'h6D) st_q <= S_WALK;
							else begin
								cnt_q <= '0; st_q <= S_GROUND;
							end
							rd_q <= '0;
							rdv_s1 <= 1'b0;
							tail_q <= 1'b0;
							wn_q <= '0;
							wb_q <= '0;
							acc_q <= '0;
							empty_q <= 1'b1;
							bad_q <= 1'b0;
							priv_q <= 1'b0;
							pidx_q <= '0;
						end else if (cnt_q >= CntW'(ParamDepth)) begin
							cnt_q <= '0; st_q <= S_GROUND;
						end else cnt_q <= cnt_q + 1'b1;
					end
					S_OSC: begin
						if (in.code_unit == 16'h07) st_q <= S_GROUND;
						else if (in.code_unit == 16'h1B) st_q <= S_OSC_ESC;
					end
					S_OSC_ESC: st_q <= S_GROUND;
					default: st_q <= (in.code_unit == 16'h1B) ? S_ESC : S_GROUND;
				endcase
			end else if (st_q == S_WALK) begin
				// issue reads; stop issuing past the last char
				rdv_s1 <= rd_q < cnt_q;
				last_s1 <= rd_q == cnt_q - 1'b1;
				if (rd_q < cnt_q) rd_q <= rd_q + 1'b1;
				if (rdv_s1) begin
					if (pidx_q == '0 && (rdata == 8'h3F || rdata == 8'h3E)) priv_q <= 1'b1;
					pidx_q <= pidx_q + 1'b1;
					if (close_part) begin
						acc_q <= '0; empty_q <= 1'b1; bad_q <= 1'b0;
					end else begin
						empty_q <= 1'b0;
						if (is_digit) acc_q <= acc_sum[16] ? NumMax : acc_sum[15:0];
						else bad_q <= 1'b1;
					end
				end
				if (fin_q == 3'd0) begin
					if (!priv_q && !(pidx_q == '0 && rdv_s1 && (rdata == 8'h3F || rdata == 8'h3E))) begin
						sty_q <= sty_n;
					end
				end
				if (close_part || (fin_q == 3'd0 && used != 3'd0)) begin
					wn_q <= nn - used;
					wb_q <= nb >> used;
					for (int k = 0; k < 5; k++)
						wv_q[k] <= (k + int'(used) < 5) ? nv[k + int'(used)] : 16'd0;
				end
				// end the walk, after the owed empty part if the last char is ';'
				if (tail_q) begin
					tail_q <= 1'b0;
					st_q <= S_FLUSH;
				end else if (rdv_s1 && last_s1) begin
					if (rdata == 8'h3B) tail_q <= 1'b1;
					else st_q <= S_FLUSH;
				end
			end else if (st_q == S_FLUSH) begin
				// drain pending SGR parts, or emit erase
				if (fin_q != 3'd0) begin
					if (!out_v_q || out.ready) begin
						cnt_q <= '0;
						st_q <= S_GROUND;
					end
				end else if (wn_q == '0 || priv_q) begin
					cnt_q <= '0;
					st_q <= S_GROUND;
				end else begin
					sty_q <= sty_n;
					wn_q <= nn - used;
					wb_q <= nb >> used;
					for (int k = 0; k < 5; k++)
						wv_q[k] <= (k + int'(used) < 5) ? nv[k + int'(used)] : 16'd0;
				end
			end
		end
	end
endmodule

[verif/ansi_escape_sgr_parser_core_tb.sv]
// Self-checking testbench for the escape-sequence parser with SGR styling.
`timescale 1ns / 1ps
module ansi_escape_sgr_parser_core_tb;
	import aesp_pkg::*;

	localparam logic [2:0] MD_GROUND = 3'd0;
	localparam logic [2:0] MD_ESC = 3'd1;
	localparam logic [2:0] MD_CSI = 3'd2;
	localparam logic [2:0] MD_OSC = 3'd3;
	localparam logic [2:0] MD_OSC_ESC = 3'd4;

	// Predict events and hold the ones still owed by the block.
	class sgr_event_board;
		logic [2:0] mode;
		logic [7:0] pbuf [ParamDepth];
		int pcnt;
		style_t sty;
		event_t owed [$];
		int errors;

		function new();
			mode = MD_GROUND;
			pcnt = 0;
			sty = '0;
			errors = 0;
		endfunction

		// Split the buffer into values and bad flags.
		function automatic void split(output int vals[$], output bit bads[$]);
			int v;
			bit empty, bad;
			v = 0;
			empty = 1;
			bad = 0;
			vals = {};
			bads = {};
			for (int i = 0; i <= pcnt; i++) begin
				if (i == pcnt || pbuf[i] == ";") begin
					vals.push_back(bad ? 0 : v);
					bads.push_back(!empty && bad);
					v = 0;
					empty = 1;
					bad = 0;
				end else begin
					empty = 0;
					if (pbuf[i] >= "0" && pbuf[i] <= "9") begin
						v = v * 10 + (pbuf[i] - "0");
						if (v > 65535) v = 65535;
					end else bad = 1;
				end
			end
		endfunction

		function automatic logic [7:0] sat8(int v);
			return (v > 255) ? 8'hFF : v[7:0];
		endfunction

		function automatic void apply_sgr();
			int vals[$];
			bit bads[$];
			int c, n;
			if (pcnt > 0 && (pbuf[0] == "?" || pbuf[0] == ">")) return;
			if (pcnt == 0) begin
				sty = '0;
				return;
			end
			split(vals, bads);
			n = vals.size();
			for (int i = 0; i < n; i++) begin
				c = vals[i];
				if (bads[i]) continue;
				case (c)
					0: sty = '0;
					1: sty.flags[0] = 1'b1;
					2: sty.flags[1] = 1'b1;
					3: sty.flags[2] = 1'b1;
					4: sty.flags[3] = 1'b1;
					7: sty.flags[4] = 1'b1;
					9: sty.flags[5] = 1'b1;
					21, 22: sty.flags[1:0] = 2'b00;
					23: sty.flags[2] = 1'b0;
					24: sty.flags[3] = 1'b0;
					27: sty.flags[4] = 1'b0;
					29: sty.flags[5] = 1'b0;
					39: sty.fsrc = SRC_DEFAULT;
					49: sty.bsrc = SRC_DEFAULT;
					38, 48: begin
						if (i + 1 < n) begin
							if (vals[i+1] == 5 && i + 2 < n) begin
								if (c == 38) begin
									sty.fsrc = SRC_INDEX;
									sty.fidx = sat8(vals[i+2]);
								end else begin
									sty.bsrc = SRC_INDEX;
									sty.bidx = sat8(vals[i+2]);
								end
								i += 2;
							end else if (vals[i+1] == 2 && i + 4 < n) begin
								if (c == 38) begin
									sty.fsrc = SRC_RGB;
									sty.frgb = {sat8(vals[i+2]), sat8(vals[i+3]),
										sat8(vals[i+4])};
								end else begin
									sty.bsrc = SRC_RGB;
									sty.brgb = {sat8(vals[i+2]), sat8(vals[i+3]),
										sat8(vals[i+4])};
								end
								i += 4;
							end
						end
					end
					default: begin
						if (c >= 30 && c <= 37) begin
							sty.fsrc = SRC_INDEX;
							sty.fidx = 8'(c - 30);
						end else if (c >= 40 && c <= 47) begin
							sty.bsrc = SRC_INDEX;
							sty.bidx = 8'(c - 40);
						end else if (c >= 90 && c <= 97) begin
							sty.fsrc = SRC_INDEX;
							sty.fidx = 8'(c - 82);
						end else if (c >= 100 && c <= 107) begin
							sty.bsrc = SRC_INDEX;
							sty.bidx = 8'(c - 92);
						end
					end
				endcase
			end
		endfunction

		function automatic void owe(logic [2:0] kind, logic [15:0] ch, logic [15:0] er,
				bit styled);
			event_t e;
			e = '0;
			e.event_kind = kind;
			e.char_code = ch;
			e.erase_mode = er;
			if (styled) begin
				e.attributes = sty.flags;
				e.fg_source = sty.fsrc;
				e.fg_index = sty.fidx;
				e.fg_rgb = sty.frgb;
				e.bg_source = sty.bsrc;
				e.bg_index = sty.bidx;
				e.bg_rgb = sty.brgb;
			end
			owed.push_back(e);
		endfunction

		function automatic logic [15:0] first_param();
			int vals[$];
			bit bads[$];
			if (pcnt == 0) return 16'd0;
			split(vals, bads);
			return 16'(vals[0]);
		endfunction

		// Advance the parser by one accepted code unit.
		function automatic void note_unit(logic [15:0] u);
			case (mode)
				MD_ESC: begin
					if (u == "[") begin
						pcnt = 0;
						mode = MD_CSI;
					end else if (u == "]") mode = MD_OSC;
					else mode = MD_GROUND;
				end
				MD_CSI: begin
					if (u >= 16'h40 && u <= 16'h7E) begin
						if (u == "m") apply_sgr();
						else if (u == "K") owe(EV_EL, 0, first_param(), 0);
						else if (u == "J") owe(EV_ED, 0, first_param(), 0);
						pcnt = 0;
						mode = MD_GROUND;
					end else if (pcnt >= ParamDepth) begin
						pcnt = 0;
						mode = MD_GROUND;
					end else begin
						pbuf[pcnt] = (u > 16'hFF) ? 8'hFF : u[7:0];
						pcnt++;
					end
				end
				MD_OSC: begin
					if (u == 16'h07) mode = MD_GROUND;
					else if (u == 16'h1B) mode = MD_OSC_ESC;
				end
				MD_OSC_ESC: mode = MD_GROUND;
				default: begin
					mode = MD_GROUND;
					if (u == 16'h1B) mode = MD_ESC;
					else if (u == 16'h0A) owe(EV_LF, 0, 0, 0);
					else if (u == 16'h0D) owe(EV_CR, 0, 0, 0);
					else if (u == 16'h08) owe(EV_BS, 0, 0, 0);
					else if (u == 16'h09) owe(EV_TAB, 0, 0, 0);
					else if (u >= 16'h20 || u == 0) owe(EV_CHAR, u, 0, 1);
				end
			endcase
		endfunction

		// Compare one event beat with the oldest owed event.
		function automatic void check_event(event_t got);
			event_t exp_ev;
			if (owed.size() == 0) begin
				$display("%0t: unexpected event, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			exp_ev = owed.pop_front();
			if (got !== exp_ev) begin
				$display("%0t: event mismatch, expected %p, actual %p", $time, exp_ev, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	aesp_in_if unit_ch();
	aesp_out_if event_ch();
	sgr_event_board board;
	int send_idle_pct;
	int recv_idle_pct;

	ansi_escape_sgr_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in(unit_ch.sink),
		.out(event_ch.source)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Check event beats and randomize ready.
	always @(posedge clk) begin
		if (arst_n) begin
			if (event_ch.valid && event_ch.ready) board.check_event(event_ch.data);
			event_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Send one code unit, with random idle gaps before it.
	task automatic send_unit(logic [15:0] u);
		while ($urandom_range(99) < send_idle_pct) begin
			unit_ch.valid <= 1'b0;
			@(posedge clk);
		end
		unit_ch.valid <= 1'b1;
		unit_ch.code_unit <= u;
		@(posedge clk);
		while (!unit_ch.ready) @(posedge clk);
		board.note_unit(u);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_unit({8'h00, s[i]});
	endtask

	task automatic send_num(int v);
		send_text($sformatf("%0d", v));
	endtask

	function automatic int rand_val();
		case ($urandom_range(5))
			0: return $urandom_range(9);
			1: return $urandom_range(110);
			2: return $urandom_range(300);
			3: return 65530 + $urandom_range(20);
			default: return $urandom_range(107);
		endcase
	endfunction

	// CSI sequence with random parameters and a random final byte, mostly m, K or J.
	task automatic send_csi_seq();
		int nparts;
		int r;
		send_unit(16'h1B);
		send_unit("[");
		r = $urandom_range(19);
		if (r == 0) send_text("?");
		else if (r == 1) send_text(">");
		nparts = $urandom_range(6);
		for (int p = 0; p < nparts; p++) begin
			if (p > 0) send_text(";");
			r = $urandom_range(19);
			if (r < 3) send_text($urandom_range(1) ? "38" : "48");
			else if (r < 5) send_text($urandom_range(1) ? "5" : "2");
			else if (r == 5) ;
			else if (r == 6) send_unit(16'(16'h0100 + $urandom_range(16'hFEFF)));
			else if (r == 7) send_text(":");
			else if (r == 8) send_text("0000000000123");
			else send_num(rand_val());
		end
		r = $urandom_range(9);
		if (r < 6) send_text("m");
		else if (r == 6) send_text("K");
		else if (r == 7) send_text("J");
		else send_unit(16'(16'h40 + $urandom_range(16'h3E)));
	endtask

	task automatic send_random_item();
		int r;
		r = $urandom_range(99);
		if (r < 40) send_unit(16'(16'h20 + $urandom_range(16'h5E)));
		else if (r < 50) send_unit(16'($urandom_range(16'hFFFF)));
		else if (r < 58) send_unit(16'($urandom_range(16'h1F)));
		else if (r < 85) send_csi_seq();
		else if (r < 90) begin
			send_unit(16'h1B);
			send_unit("]");
			send_text("0;title");
			if ($urandom_range(1)) send_unit(16'h07);
			else begin
				send_unit(16'h1B);
				send_unit(16'($urandom_range(16'hFFFF)));
			end
		end else if (r < 93) begin
			send_unit(16'h1B);
			send_unit("[");
			for (int i = 0; i < ParamDepth + 1; i++) send_text("1");
		end else if (r < 96) begin
			send_unit(16'h1B);
			send_unit(16'($urandom_range(16'hFFFF)));
		end else send_unit({$urandom_range(1) ? 16'hFFFF : 16'h0000});
	endtask

	task automatic send_directed();
		send_unit(16'h0000);
		send_unit(16'hFFFF);
		send_unit(16'h7F);
		send_unit(16'h0A);
		send_unit(16'h0D);
		send_unit(16'h08);
		send_unit(16'h09);
		send_unit(16'h01);
		send_text("\033[1;2;3;4;7;9;31;42mA");
		send_text("\033[38;2;300;1;255;48;5;999mB");
		send_text("\033[22;23;24;27;29;39;49;97;107mC");
		send_text("\033[?1mD\033[mE\033[38;7;1m;F");
		send_text("\033[2K\033[99999J\033[xJ\033[K\033[Z");
		send_text("\033]0;t\007G\033]x\033\\H\033QI");
	endtask

	task automatic run_phase(int sp, int rp, int n);
		send_idle_pct = sp;
		recv_idle_pct = rp;
		for (int i = 0; i < n; i++) send_random_item();
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		unit_ch.valid = 1'b0;
		unit_ch.code_unit = '0;
		event_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_directed();
		run_phase(29, 72, 70);
		run_phase(72, 29, 70);
		run_phase(0, 0, 70);
		unit_ch.valid <= 1'b0;
		recv_idle_pct = 0;
		while (board.owed.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (board.errors == 0) $display("ALL CHECKS PASSED");
		else $display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
